// File: hdl/pbrs_pkg.sv
// ----------------------------------------------------------------------------
// pbrs_pkg
// Shared types and codes for the bitmap priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package pbrs_pkg;

	// Table sizes, matched to the 5-bit thread and priority fields.
	localparam int NUM_PRIORITIES = 32;
	localparam int NUM_THREADS    = 32;

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_REMOVE = 3'd1,
		FN_SCHED  = 3'd2,
		FN_ENTER  = 3'd3,
		FN_EXIT   = 3'd4,
		FN_START  = 3'd5
	} func_t;

	localparam logic [1:0] KIND_TASK  = 2'd0;
	localparam logic [1:0] KIND_IRQ   = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [14:0] LOCK_MAX = 15'd32767;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the request
		logic rd;       // issue table reads for the latched request
		logic exec;     // perform the update and form the result
	} pbrs_cmd_t;

endpackage

// File: hdl/pbrs_ctrl.sv
// ----------------------------------------------------------------------------
// pbrs_ctrl
// Sequencer: capture, table read, execute, result, then back to idle.
// ----------------------------------------------------------------------------
module pbrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output pbrs_pkg::pbrs_cmd_t cmd
);
	import pbrs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_RD;
			ST_RD:   state_d = ST_EXEC;
			ST_EXEC: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.rd      = (state_q == ST_RD);
	assign cmd.exec    = (state_q == ST_EXEC);
endmodule

// File: hdl/pbrs_dp.sv
// ----------------------------------------------------------------------------
// pbrs_dp
// Datapath: link tables, ready bitmap, running thread and lock depth.
// ----------------------------------------------------------------------------
module pbrs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pbrs_pkg::pbrs_cmd_t cmd,
	input  logic [2:0]          func,
	input  logic [4:0]          thread_id,
	input  logic [4:0]          priority_req,
	input  logic                in_interrupt,
	output logic                done,
	output logic                switched,
	output logic [1:0]          switch_kind,
	output logic                from_valid,
	output logic [4:0]          old_thread,
	output logic [4:0]          new_thread,
	output logic [4:0]          to_priority,
	output logic [31:0]         ready_bits,
	output logic [14:0]         lock_level,
	output logic                status
);
	import pbrs_pkg::*;

	localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
	localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

	// Tables, contents undefined until written.
	logic [TW-1:0] head_mem [NUM_PRIORITIES];
	logic [TW-1:0] tail_mem [NUM_PRIORITIES];
	logic [TW-1:0] next_mem [NUM_THREADS];
	logic [TW-1:0] prev_mem [NUM_THREADS];
	logic [PW-1:0] prio_mem [NUM_THREADS];

	logic [NUM_THREADS-1:0]    queued_q;
	logic [NUM_PRIORITIES-1:0] ready_q;
	logic [TW-1:0]             run_thr_q;
	logic                      run_valid_q;
	logic [14:0]               lock_q;

	// Latched request.
	logic [2:0]    func_q;
	logic [4:0]    tid_q, prq_q;
	logic          irq_q;
	logic [PW-1:0] tp_q;

	// The thread's own priority is read as the request is taken, so that the
	// head and tail of its queue can be read in the next step.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			tid_q  <= thread_id;
			prq_q  <= priority_req;
			irq_q  <= in_interrupt;
			tp_q   <= prio_mem[thread_id[TW-1:0]];
		end
	end

	logic          tid_ok, prq_ok;
	logic [TW-1:0] tid_n;
	logic [PW-1:0] prq_n;
	assign tid_ok = ({27'd0, tid_q} < 32'(NUM_THREADS));
	assign prq_ok = ({27'd0, prq_q} < 32'(NUM_PRIORITIES));
	assign tid_n  = tid_q[TW-1:0];
	assign prq_n  = prq_q[PW-1:0];

	// Lowest set bit of the ready bitmap.
	logic [PW-1:0] best_p;
	always_comb begin
		best_p = '0;
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
			if (ready_q[i]) best_p = PW'(i);
	end

	// Table read step: the thread's links, its queue's head and tail, the
	// tail of the insert priority and the best head.
	logic [TW-1:0] nx_q, pv_q, ins_tail_q, best_head_q, rm_head_q, rm_tail_q;
	logic [PW-1:0] best_p_q;
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			nx_q        <= next_mem[tid_n];
			pv_q        <= prev_mem[tid_n];
			ins_tail_q  <= tail_mem[prq_n];
			best_head_q <= head_mem[best_p];
			best_p_q    <= best_p;
			rm_head_q   <= head_mem[tp_q];
			rm_tail_q   <= tail_mem[tp_q];
		end
	end

	// Lock depth after enter or exit.
	logic [14:0] lock_n;
	always_comb begin
		lock_n = lock_q;
		if (func_q == FN_ENTER && lock_q != LOCK_MAX) lock_n = lock_q + 15'd1;
		if (func_q == FN_EXIT && lock_q != 15'd0)     lock_n = lock_q - 15'd1;
	end

	logic fn_ins, fn_rem, fn_sch, fn_st, bad_fn, ins_ok, rem_ok, is_h, is_t;
	logic sch_go, sw;
	assign fn_ins = (func_q == FN_INSERT);
	assign fn_rem = (func_q == FN_REMOVE);
	assign fn_sch = (func_q == FN_SCHED) || (func_q == FN_EXIT);
	assign fn_st  = (func_q == FN_START);
	assign bad_fn = (func_q > FN_START);
	assign ins_ok = fn_ins && tid_ok && prq_ok && !queued_q[tid_n];
	assign rem_ok = fn_rem && tid_ok && queued_q[tid_n];
	assign is_h   = (rm_head_q == tid_n);
	assign is_t   = (rm_tail_q == tid_n);
	assign sch_go = fn_sch && (lock_n == 15'd0) && (ready_q != '0)
		&& !(run_valid_q && best_head_q == run_thr_q);
	assign sw     = sch_go || (fn_st && ready_q != '0);

	// Table and state updates.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (ins_ok) begin
				if (!ready_q[prq_n]) head_mem[prq_n] <= tid_n;
				else begin
					next_mem[ins_tail_q] <= tid_n;
					prev_mem[tid_n]      <= ins_tail_q;
				end
				tail_mem[prq_n] <= tid_n;
				prio_mem[tid_n] <= prq_n;
			end
			if (rem_ok && !(is_h && is_t)) begin
				if (is_h) head_mem[tp_q] <= nx_q;
				else      next_mem[pv_q] <= nx_q;
				if (is_t) tail_mem[tp_q] <= pv_q;
				else      prev_mem[nx_q] <= pv_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q    <= '0;
			ready_q     <= '0;
			run_thr_q   <= '0;
			run_valid_q <= 1'b0;
			lock_q      <= '0;
			done        <= 1'b0;
		end else begin
			done <= cmd.exec;
			if (cmd.exec) begin
				lock_q <= lock_n;
				if (ins_ok) begin
					queued_q[tid_n] <= 1'b1;
					ready_q[prq_n]  <= 1'b1;
				end
				if (rem_ok) begin
					queued_q[tid_n] <= 1'b0;
					if (is_h && is_t) ready_q[tp_q] <= 1'b0;
				end
				if (sw) begin
					run_thr_q   <= best_head_q;
					run_valid_q <= 1'b1;
				end
			end
		end
	end

	// Result register.
	logic [NUM_PRIORITIES-1:0] ready_next;
	always_comb begin
		ready_next = ready_q;
		if (ins_ok) ready_next[prq_n] = 1'b1;
		if (rem_ok && is_h && is_t) ready_next[tp_q] = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			switched    <= sw;
			switch_kind <= !sw ? KIND_TASK : fn_st ? KIND_START
				: irq_q ? KIND_IRQ : KIND_TASK;
			from_valid  <= sch_go && run_valid_q;
			old_thread  <= (sch_go && run_valid_q) ? 5'(run_thr_q) : 5'd0;
			new_thread  <= sw ? 5'(best_head_q) : 5'd0;
			to_priority <= sw ? 5'(best_p_q) : 5'd0;
			ready_bits  <= 32'(ready_next);
			lock_level  <= lock_n;
			status      <= bad_fn || (fn_ins && !ins_ok) || (fn_rem && !rem_ok);
		end
	end
endmodule

// File: hdl/priority_bitmap_ready_scheduler.sv
// ----------------------------------------------------------------------------
// priority_bitmap_ready_scheduler
// Ready-queue scheduler with per-priority FIFOs and a ready bitmap.
// ----------------------------------------------------------------------------
// Usage: drive func, thread_id, priority_req and in_interrupt and raise start
// while busy is low; the command item is taken at that edge. busy then stays
// high through the table read, execute and result steps. Exactly one result
// follows per item: after the table read and execute steps, done is high for
// one cycle with switched, kind, old and new thread, priority, ready bitmap,
// lock level and status on the result ports. busy falls together with done,
// so the block takes no new item before the last one's result is out; this
// is set by the sequencer's capture, table read, execute and result steps.
// Results cannot be held off by the receiver and must be taken on the strobe.
// Reset clears the ready bitmap, queued flags, lock depth and running thread;
// the link tables need no clearing, as they are only read behind a set ready
// or queued bit.
// ----------------------------------------------------------------------------
module priority_bitmap_ready_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [4:0]  thread_id,
	input  logic [4:0]  priority_req,
	input  logic        in_interrupt,
	output logic        done,
	output logic        switched,
	output logic [1:0]  switch_kind,
	output logic        from_valid,
	output logic [4:0]  old_thread,
	output logic [4:0]  new_thread,
	output logic [4:0]  to_priority,
	output logic [31:0] ready_bits,
	output logic [14:0] lock_level,
	output logic        status
);
	import pbrs_pkg::*;

	pbrs_cmd_t cmd;

	// Sequencer.
	pbrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Tables and state.
	pbrs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.in_interrupt (in_interrupt),
		.done         (done),
		.switched     (switched),
		.switch_kind  (switch_kind),
		.from_valid   (from_valid),
		.old_thread   (old_thread),
		.new_thread   (new_thread),
		.to_priority  (to_priority),
		.ready_bits   (ready_bits),
		.lock_level   (lock_level),
		.status       (status)
	);
endmodule

// File: tb/tb_priority_bitmap_ready_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_bitmap_ready_scheduler
// Self-checking bench for the bitmap priority ready-queue scheduler. Command
// items are sent with random gaps, the expected result of each item is worked
// out by a behavioural model of the ready queues, and every result taken on
// the done strobe is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_priority_bitmap_ready_scheduler;
	import pbrs_pkg::*;

	localparam int NPRIO = 32;
	localparam int NTHR  = 32;

	typedef struct packed {
		logic        switched;
		logic [1:0]  switch_kind;
		logic        from_valid;
		logic [4:0]  old_thread;
		logic [4:0]  new_thread;
		logic [4:0]  to_priority;
		logic [31:0] ready_bits;
		logic [14:0] lock_level;
		logic        status;
	} sched_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [4:0]  thread_id;
	logic [4:0]  priority_req;
	logic        in_interrupt;
	logic        done;
	logic        switched;
	logic [1:0]  switch_kind;
	logic        from_valid;
	logic [4:0]  old_thread;
	logic [4:0]  new_thread;
	logic [4:0]  to_priority;
	logic [31:0] ready_bits;
	logic [14:0] lock_level;
	logic        status;

	// Model of the scheduler state.
	logic [31:0] m_ready;
	logic [4:0]  m_head [NPRIO];
	logic [4:0]  m_tail [NPRIO];
	logic [4:0]  m_next [NTHR];
	logic [4:0]  m_prev [NTHR];
	logic [4:0]  m_prio [NTHR];
	logic        m_queued [NTHR];
	logic [4:0]  m_run;
	logic        m_run_valid;
	logic [14:0] m_lock;

	sched_res_t  pending_results [$];
	int          n_errors;
	int          n_items;
	int          n_switches;
	int          sender_idle_pct;

	priority_bitmap_ready_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.in_interrupt (in_interrupt),
		.done         (done),
		.switched     (switched),
		.switch_kind  (switch_kind),
		.from_valid   (from_valid),
		.old_thread   (old_thread),
		.new_thread   (new_thread),
		.to_priority  (to_priority),
		.ready_bits   (ready_bits),
		.lock_level   (lock_level),
		.status       (status)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Picks the best ready thread and records a switch, as schedule and start do.
	function automatic void pick_thread(input logic [1:0] kind, input logic is_start,
			inout sched_res_t r);
		int p;
		logic [4:0] to;
		if (m_ready == 32'd0) begin
			return;
		end
		p = 0;
		while (!m_ready[p]) p++;
		to = m_head[p];
		if (!is_start && m_run_valid && to == m_run) begin
			return;
		end
		r.switched    = 1'b1;
		r.switch_kind = kind;
		r.from_valid  = is_start ? 1'b0 : m_run_valid;
		r.old_thread  = (!is_start && m_run_valid) ? m_run : 5'd0;
		r.new_thread  = to;
		r.to_priority = 5'(p);
		m_run         = to;
		m_run_valid   = 1'b1;
	endfunction

	// Applies one command to the model and returns the expected result.
	function automatic sched_res_t predict_command(input logic [2:0] f, input logic [4:0] t,
			input logic [4:0] p, input logic irq);
		sched_res_t r;
		logic [4:0] q, nx, pv;
		logic is_head, is_tail;
		r = '0;
		case (f)
			FN_INSERT: begin
				if (m_queued[t]) begin
					r.status = 1'b1;
				end else begin
					if (!m_ready[p]) begin
						m_head[p] = t;
					end else begin
						m_next[m_tail[p]] = t;
						m_prev[t] = m_tail[p];
					end
					m_tail[p] = t;
					m_prio[t] = p;
					m_queued[t] = 1'b1;
					m_ready[p] = 1'b1;
				end
			end
			FN_REMOVE: begin
				if (!m_queued[t]) begin
					r.status = 1'b1;
				end else begin
					q = m_prio[t];
					nx = m_next[t];
					pv = m_prev[t];
					is_head = (m_head[q] == t);
					is_tail = (m_tail[q] == t);
					if (is_head && is_tail) begin
						m_ready[q] = 1'b0;
					end else begin
						if (is_head) m_head[q] = nx;
						else m_next[pv] = nx;
						if (is_tail) m_tail[q] = pv;
						else m_prev[nx] = pv;
					end
					m_queued[t] = 1'b0;
				end
			end
			FN_SCHED: begin
				if (m_lock == 15'd0) pick_thread(irq ? KIND_IRQ : KIND_TASK, 1'b0, r);
			end
			FN_ENTER: begin
				if (m_lock != LOCK_MAX) m_lock = m_lock + 15'd1;
			end
			FN_EXIT: begin
				if (m_lock != 15'd0) m_lock = m_lock - 15'd1;
				if (m_lock == 15'd0) pick_thread(irq ? KIND_IRQ : KIND_TASK, 1'b0, r);
			end
			FN_START: begin
				pick_thread(KIND_START, 1'b1, r);
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		r.ready_bits = m_ready;
		r.lock_level = m_lock;
		return r;
	endfunction

	// Sends one command item, with a random gap first, and queues its expectation.
	// start is left high after acceptance; the block is busy then, and the next
	// call either drops it for a gap or drives the next item.
	task automatic send_command(input logic [2:0] f, input logic [4:0] t,
			input logic [4:0] p, input logic irq);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		func         <= f;
		thread_id    <= t;
		priority_req <= p;
		in_interrupt <= irq;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_command(f, t, p, irq));
		n_items++;
		@(negedge clk);
	endtask

	task automatic wait_results_drained;
		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Result checker: compares each strobed result with the oldest expectation.
	always @(posedge clk) begin
		sched_res_t got, exp_r;
		if (arst_n && done) begin
			got = {switched, switch_kind, from_valid, old_thread, new_thread,
				to_priority, ready_bits, lock_level, status};
			if (pending_results.size() == 0) begin
				$display("%0t: result with no item waiting: %p", $realtime, got);
				n_errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.switched) n_switches++;
				if (got !== exp_r) begin
					$display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
					n_errors++;
				end
			end
		end
	end

	// Extremes: empty scheduler, invalid codes, lock and release.
	task automatic test_directed;
		send_command(FN_SCHED, 5'd0, 5'd0, 1'b0);
		send_command(FN_START, 5'd0, 5'd0, 1'b0);
		send_command(FN_EXIT, 5'd0, 5'd0, 1'b1);
		send_command(FN_REMOVE, 5'd31, 5'd0, 1'b0);
		send_command(FN_INSERT, 5'd31, 5'd31, 1'b0);
		send_command(FN_INSERT, 5'd31, 5'd0, 1'b0);
		send_command(FN_INSERT, 5'd0, 5'd31, 1'b0);
		send_command(FN_INSERT, 5'd5, 5'd0, 1'b0);
		send_command(FN_START, 5'd0, 5'd0, 1'b1);
		send_command(FN_SCHED, 5'd0, 5'd0, 1'b0);
		send_command(FN_ENTER, 5'd0, 5'd0, 1'b0);
		send_command(FN_REMOVE, 5'd5, 5'd0, 1'b0);
		send_command(FN_SCHED, 5'd0, 5'd0, 1'b1);
		send_command(FN_EXIT, 5'd0, 5'd0, 1'b1);
		send_command(FN_START, 5'd0, 5'd0, 1'b0);
		send_command(3'd6, 5'd21, 5'd10, 1'b1);
		send_command(3'd7, 5'd10, 5'd21, 1'b0);
		send_command(FN_REMOVE, 5'd31, 5'd0, 1'b0);
		send_command(FN_SCHED, 5'd0, 5'd0, 1'b0);
		wait_results_drained();
	endtask

	// Nests the lock at least seventeen levels deep and unwinds it past zero.
	task automatic test_lock_nesting;
		sender_idle_pct = 0;
		repeat (16) send_command(FN_ENTER, 5'($urandom), 5'($urandom), 1'($urandom));
		send_command(FN_SCHED, 5'd0, 5'd0, 1'b0);
		send_command(FN_EXIT, 5'd0, 5'd0, 1'b0);
		send_command(FN_ENTER, 5'd0, 5'd0, 1'b0);
		send_command(FN_ENTER, 5'd0, 5'd0, 1'b0);
		while (m_lock != 15'd0) send_command(FN_EXIT, 5'($urandom), 5'd0, 1'($urandom));
		send_command(FN_EXIT, 5'd0, 5'd0, 1'b0);
		wait_results_drained();
	endtask

	// Random commands weighted towards queue churn and scheduling.
	task automatic test_random_phase(input int count, input int idle_pct);
		int sel;
		logic [2:0] f;
		sender_idle_pct = idle_pct;
		repeat (count) begin
			sel = $urandom_range(99);
			if (sel < 35) f = FN_INSERT;
			else if (sel < 60) f = FN_REMOVE;
			else if (sel < 75) f = FN_SCHED;
			else if (sel < 83) f = FN_ENTER;
			else if (sel < 93) f = FN_EXIT;
			else if (sel < 97) f = FN_START;
			else f = 3'($urandom_range(7, 6));
			send_command(f, 5'($urandom_range(sel[0] ? 7 : 31)),
				5'($urandom_range(sel[1] ? 3 : 31)), 1'($urandom));
		end
		wait_results_drained();
	endtask

	initial begin
		n_errors        = 0;
		n_items         = 0;
		n_switches      = 0;
		sender_idle_pct = 0;
		m_ready         = '0;
		m_run           = '0;
		m_run_valid     = 1'b0;
		m_lock          = '0;
		for (int i = 0; i < NTHR; i++) m_queued[i] = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		func         = '0;
		thread_id    = '0;
		priority_req = '0;
		in_interrupt = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_phase(100, 0);
		test_random_phase(100, 60);
		test_random_phase(100, 26);
		test_lock_nesting();
		test_random_phase(100, 0);

		$display("Covered %0d items, %0d context switches, nested locking and release,",
			n_items, n_switches);
		$display("invalid codes, duplicate inserts and removes of unqueued threads.");
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
